/* rtl/lrf_pkg.sv */
`default_nettype none

package lrf_pkg;

   localparam int FRAMES  = 64;
   localparam int FRAME_W = $clog2(FRAMES);
   localparam int COUNT_W = $clog2(FRAMES + 1);
   localparam int CMD_W   = 2;

   localparam logic [COUNT_W-1:0] CAPACITY_RESET = COUNT_W'(FRAMES);

   typedef enum logic [CMD_W-1:0] {
      CMD_VICTIM = 2'd0,
      CMD_PIN    = 2'd1,
      CMD_UNPIN  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic load_req;
      logic tgt_oldest;
      logic tgt_frame;
      logic capture;
      logic rd;
      logic unlink;
      logic push;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             count_zero;
      logic             evict_needed;
      logic             frame_present;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/lrf_req_if.sv */
`default_nettype none

interface lrf_req_if;
   logic                        valid;
   logic                        ready;
   logic [lrf_pkg::CMD_W-1:0]   cmd;
   logic [lrf_pkg::FRAME_W-1:0] frame;

   modport source (output valid, output cmd, output frame, input ready);
   modport sink (input valid, input cmd, input frame, output ready);
endinterface

`default_nettype wire

/* rtl/lrf_rsp_if.sv */
`default_nettype none

interface lrf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [lrf_pkg::FRAME_W-1:0] out_frame;
   logic [lrf_pkg::COUNT_W-1:0] occupancy;

   modport source (output valid, output found, output out_frame, output occupancy,
                   input ready);
   modport sink (input valid, input found, input out_frame, input occupancy,
                 output ready);
endinterface

`default_nettype wire

/* rtl/lrf_datapath.sv */
`default_nettype none

module lrf_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lrf_pkg::ctrl_cmd_type       ctrl,
   output lrf_pkg::dp_status_type           status,
   input  wire logic [lrf_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [lrf_pkg::FRAME_W-1:0] req_frame,
   input  wire logic                        csr_wr_en,
   input  wire logic [lrf_pkg::COUNT_W-1:0] csr_wr_data,
   output logic                             rsp_found,
   output logic [lrf_pkg::FRAME_W-1:0]      rsp_out_frame,
   output logic [lrf_pkg::COUNT_W-1:0]      rsp_occupancy
);

   logic [lrf_pkg::FRAME_W-1:0] next_mem [lrf_pkg::FRAMES];
   logic [lrf_pkg::FRAME_W-1:0] prev_mem [lrf_pkg::FRAMES];

   logic [lrf_pkg::FRAMES-1:0]  present_ff, present_in;
   logic [lrf_pkg::FRAME_W-1:0] newest_ff, newest_in;
   logic [lrf_pkg::FRAME_W-1:0] oldest_ff, oldest_in;
   logic [lrf_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [lrf_pkg::COUNT_W-1:0] capacity_ff, capacity_in;

   logic [lrf_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [lrf_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [lrf_pkg::FRAME_W-1:0] target_ff, target_in;
   logic                        found_ff, found_in;
   logic [lrf_pkg::FRAME_W-1:0] got_ff, got_in;
   logic [lrf_pkg::FRAME_W-1:0] next_rd_ff;
   logic [lrf_pkg::FRAME_W-1:0] prev_rd_ff;

   logic                        rsp_found_ff, rsp_found_in;
   logic [lrf_pkg::FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic [lrf_pkg::COUNT_W-1:0] rsp_occ_ff, rsp_occ_in;

   logic [lrf_pkg::COUNT_W-1:0] cap_eff;

   always_comb begin
      priority if (capacity_ff == '0) begin
         cap_eff = lrf_pkg::COUNT_W'(1);
      end else if (capacity_ff > lrf_pkg::CAPACITY_RESET) begin
         cap_eff = lrf_pkg::CAPACITY_RESET;
      end else begin
         cap_eff = capacity_ff;
      end
   end

   assign status.cmd           = cmd_ff;
   assign status.count_zero    = (count_ff == '0);
   assign status.evict_needed  = (count_ff != '0) && (count_ff >= cap_eff);
   assign status.frame_present = present_ff[frame_ff];

   always_ff @(posedge clock) begin
      if (ctrl.rd) begin
         next_rd_ff <= next_mem[target_ff];
         prev_rd_ff <= prev_mem[target_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.unlink && (target_ff != newest_ff)) begin
         next_mem[prev_rd_ff] <= next_rd_ff;
      end else if (ctrl.push) begin
         next_mem[frame_ff] <= newest_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.unlink && (target_ff != oldest_ff)) begin
         prev_mem[next_rd_ff] <= prev_rd_ff;
      end else if (ctrl.push && (count_ff != '0)) begin
         prev_mem[newest_ff] <= frame_ff;
      end
   end

   always_comb begin
      present_in   = present_ff;
      newest_in    = newest_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      capacity_in  = capacity_ff;
      cmd_in       = cmd_ff;
      frame_in     = frame_ff;
      target_in    = target_ff;
      found_in     = found_ff;
      got_in       = got_ff;
      rsp_found_in = rsp_found_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_occ_in   = rsp_occ_ff;

      if (ctrl.load_req) begin
         cmd_in   = req_cmd;
         frame_in = req_frame;
         found_in = 1'b0;
         got_in   = '0;
      end
      if (ctrl.tgt_oldest) begin
         target_in = oldest_ff;
      end
      if (ctrl.tgt_frame) begin
         target_in = frame_ff;
      end
      if (ctrl.capture && !found_ff) begin
         found_in = 1'b1;
         got_in   = oldest_ff;
      end
      if (ctrl.unlink) begin
         if (target_ff == newest_ff) begin
            newest_in = next_rd_ff;
         end
         if (target_ff == oldest_ff) begin
            oldest_in = prev_rd_ff;
         end
         present_in[target_ff] = 1'b0;
         count_in = count_ff - lrf_pkg::COUNT_W'(1);
         if (count_ff == lrf_pkg::COUNT_W'(1)) begin
            newest_in = '0;
            oldest_in = '0;
         end
      end
      if (ctrl.push) begin
         newest_in = frame_ff;
         if (count_ff == '0) begin
            oldest_in = frame_ff;
         end
         present_in[frame_ff] = 1'b1;
         count_in = count_ff + lrf_pkg::COUNT_W'(1);
      end
      if (csr_wr_en) begin
         capacity_in = csr_wr_data;
      end
      if (ctrl.load_rsp) begin
         rsp_found_in = found_ff;
         rsp_frame_in = found_ff ? got_ff : '0;
         rsp_occ_in   = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= '0;
         newest_ff   <= '0;
         oldest_ff   <= '0;
         count_ff    <= '0;
         capacity_ff <= lrf_pkg::CAPACITY_RESET;
      end else begin
         present_ff  <= present_in;
         newest_ff   <= newest_in;
         oldest_ff   <= oldest_in;
         count_ff    <= count_in;
         capacity_ff <= capacity_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      frame_ff     <= frame_in;
      target_ff    <= target_in;
      found_ff     <= found_in;
      got_ff       <= got_in;
      rsp_found_ff <= rsp_found_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_occ_ff   <= rsp_occ_in;
   end

   assign rsp_found     = rsp_found_ff;
   assign rsp_out_frame = rsp_frame_ff;
   assign rsp_occupancy = rsp_occ_ff;

   a_unlink_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.unlink |-> (count_ff != '0) && present_ff[target_ff])
      else $error("unlink of a frame that is not tracked");

   a_push_absent: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> !present_ff[frame_ff] && (count_ff < cap_eff))
      else $error("push of a tracked frame or into a full set");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(present_ff) == 32'(count_ff))
      else $error("occupancy disagrees with the tracked frames");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (newest_ff == '0) && (oldest_ff == '0))
      else $error("list ends not cleared in an empty set");

endmodule

`default_nettype wire

/* rtl/lrf_controller.sv */
`default_nettype none

module lrf_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire lrf_pkg::dp_status_type status,
   output lrf_pkg::ctrl_cmd_type      ctrl
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DISPATCH = 7'b0000010,
      ST_READ     = 7'b0000100,
      ST_UNLINK   = 7'b0001000,
      ST_PUSH     = 7'b0010000,
      ST_DONE     = 7'b0100000,
      ST_SPARE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      ctrl         = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.load_req = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.cmd)
               lrf_pkg::CMD_VICTIM: begin
                  if (status.count_zero) begin
                     state_in = ST_DONE;
                  end else begin
                     ctrl.tgt_oldest = 1'b1;
                     ctrl.capture    = 1'b1;
                     state_in        = ST_READ;
                  end
               end
               lrf_pkg::CMD_PIN: begin
                  if (status.frame_present) begin
                     ctrl.tgt_frame = 1'b1;
                     state_in       = ST_READ;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               lrf_pkg::CMD_UNPIN: begin
                  priority if (status.evict_needed) begin
                     ctrl.tgt_oldest = 1'b1;
                     ctrl.capture    = 1'b1;
                     state_in        = ST_READ;
                  end else if (status.frame_present) begin
                     ctrl.tgt_frame = 1'b1;
                     state_in       = ST_READ;
                  end else begin
                     state_in = ST_PUSH;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_READ: begin
            ctrl.rd  = 1'b1;
            state_in = ST_UNLINK;
         end
         ST_UNLINK: begin
            ctrl.unlink = 1'b1;
            if (status.cmd == lrf_pkg::CMD_UNPIN) begin
               state_in = ST_DISPATCH;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PUSH: begin
            ctrl.push = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.load_rsp = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff) && (state_ff != ST_SPARE))
      else $error("controller state is not a legal one-hot code");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |-> !rsp_valid_ff || rsp_ready)
      else $error("response register reloaded before it was taken");

   a_accept_then_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted request was not dispatched");

endmodule

`default_nettype wire

/* rtl/lru_frame_replacer_unit.sv */
// LRU frame replacer: tracks evictable buffer frames in recency order.
// Requests arrive on req_chan (cmd: victim, pin or unpin; frame number) and
// each request produces exactly one response on rsp_chan carrying found,
// out_frame and the occupancy after the command. The capacity register is
// written through csr_wr_en and csr_wr_data; the user must write it only
// while no request is in flight, which the block itself does not enforce.
// One request is processed at a time by a controller that drives a datapath
// with two link memories (next and previous) of one read and one write port.
// Each unlink is a registered read of the link memories and then a write.
// An unpin evicts the oldest frames while the set is full and unlinks the
// frame if it was already tracked; every unlink of an unpin returns to
// dispatch. A new request is accepted in the cycle after the previous
// response is loaded. The response sits in an output register; a stalled
// receiver holds it, and the next request is still accepted and processed,
// waiting in its last step until the output register is free. Synchronous
// reset empties the set, sets capacity to 64 and drops any pending response.
`default_nettype none

module lru_frame_replacer_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   lrf_req_if.sink                          req_chan,
   lrf_rsp_if.source                        rsp_chan,
   input  wire logic                        csr_wr_en,
   input  wire logic [lrf_pkg::COUNT_W-1:0] csr_wr_data
);

   lrf_pkg::ctrl_cmd_type  ctrl;
   lrf_pkg::dp_status_type status;

   lrf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   lrf_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .status        (status),
      .req_cmd       (req_chan.cmd),
      .req_frame     (req_chan.frame),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_found     (rsp_chan.found),
      .rsp_out_frame (rsp_chan.out_frame),
      .rsp_occupancy (rsp_chan.occupancy)
   );

endmodule

`default_nettype wire

/* sim/lru_frame_replacer_unit_tb.sv */
`default_nettype none

module lru_frame_replacer_unit_tb;
   import lrf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
   localparam int REQUEST_TOTAL = 1950;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic               found;
      logic [FRAME_W-1:0] out_frame;
      logic [COUNT_W-1:0] occupancy;
   } lru_rsp_type;

   typedef enum logic {ROW_REQ, ROW_CAP} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [CMD_W-1:0]   cmd;
      logic [FRAME_W-1:0] frame;
      logic [COUNT_W-1:0] cap;
      logic               typed;
      lru_rsp_type        rsp;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   lrf_req_if req_chan ();
   lrf_rsp_if rsp_chan ();

   lru_frame_replacer_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the recency list, most recent frame at the head.
   bit                 in_set[FRAMES];
   logic [FRAME_W-1:0] next_q[FRAMES];
   logic [FRAME_W-1:0] prev_q[FRAMES];
   logic [FRAME_W-1:0] newest_q;
   logic [FRAME_W-1:0] oldest_q;
   int                 occ_q;
   logic [COUNT_W-1:0] cap_q;

   lru_rsp_type  lru_rsp_due[$];
   plan_row_type directed_plan[$];
   logic         known_on;
   lru_rsp_type  known_rsp;
   int           err_count = 0;
   int           req_total = 0;
   int           idle_cycles = 0;

   function automatic void lru_reset();
      foreach (in_set[i]) in_set[i] = 1'b0;
      newest_q = '0;
      oldest_q = '0;
      occ_q    = 0;
      cap_q    = CAPACITY_RESET;
   endfunction

   function automatic void lru_drop(logic [FRAME_W-1:0] f);
      logic [FRAME_W-1:0] p;
      logic [FRAME_W-1:0] n;
      if (!in_set[f]) return;
      p = prev_q[f];
      n = next_q[f];
      if (f == newest_q) newest_q = n;
      else next_q[p] = n;
      if (f == oldest_q) oldest_q = p;
      else prev_q[n] = p;
      in_set[f] = 1'b0;
      occ_q--;
      if (occ_q == 0) begin
         newest_q = '0;
         oldest_q = '0;
      end
   endfunction

   function automatic void lru_put_front(logic [FRAME_W-1:0] f);
      next_q[f] = newest_q;
      prev_q[f] = f;
      if (occ_q == 0) oldest_q = f;
      else prev_q[newest_q] = f;
      newest_q  = f;
      in_set[f] = 1'b1;
      occ_q++;
   endfunction

   function automatic lru_rsp_type lru_apply(logic [CMD_W-1:0] c, logic [FRAME_W-1:0] f);
      lru_rsp_type r;
      int lim;
      logic [FRAME_W-1:0] v;
      r   = '0;
      lim = int'(cap_q);
      if (lim == 0) lim = 1;
      if (lim > FRAMES) lim = FRAMES;
      case (c)
         CMD_VICTIM: begin
            if (occ_q != 0) begin
               r.found     = 1'b1;
               r.out_frame = oldest_q;
               lru_drop(oldest_q);
            end
         end
         CMD_PIN: lru_drop(f);
         CMD_UNPIN: begin
            // A full set gives up its oldest frames before the frame moves to the front.
            while (occ_q != 0 && occ_q >= lim) begin
               v = oldest_q;
               if (!r.found) begin
                  r.found     = 1'b1;
                  r.out_frame = v;
               end
               lru_drop(v);
            end
            lru_drop(f);
            lru_put_front(f);
         end
         default: ;
      endcase
      r.occupancy = COUNT_W'(occ_q);
      return r;
   endfunction

   task automatic check_rsp(input lru_rsp_type want, input lru_rsp_type got);
      if (got.found !== want.found) begin
         $error("found: expected %0d, got %0d", want.found, got.found);
         err_count++;
      end
      if (got.out_frame !== want.out_frame) begin
         $error("out_frame: expected %0d, got %0d", want.out_frame, got.out_frame);
         err_count++;
      end
      if (got.occupancy !== want.occupancy) begin
         $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
         err_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      lru_rsp_type want;
      lru_rsp_type got;
      bit busy;
      if (reset) begin
         lru_reset();
         idle_cycles = 0;
      end else begin
         busy = 1'b0;
         if (csr_wr_en) begin
            cap_q = csr_wr_data;
            busy  = 1'b1;
         end
         if (req_chan.valid && req_chan.ready) begin
            want = lru_apply(req_chan.cmd, req_chan.frame);
            if (known_on) want = known_rsp;
            lru_rsp_due.push_back(want);
            busy = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            busy = 1'b1;
            got.found     = rsp_chan.found;
            got.out_frame = rsp_chan.out_frame;
            got.occupancy = rsp_chan.occupancy;
            if (lru_rsp_due.size() == 0) begin
               $error("Response with no request outstanding: found %0d, out_frame %0d",
                      got.found, got.out_frame);
               err_count++;
            end else begin
               check_rsp(lru_rsp_due.pop_front(), got);
            end
         end
         idle_cycles = busy ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : rsp_stalls
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_chan.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(40, 200)) @(posedge clock);
         else repeat ($urandom_range(1, 4)) @(posedge clock);
         rsp_chan.ready <= 1'b0;
         if ($urandom_range(0, 99) < 90) repeat ($urandom_range(1, 3)) @(posedge clock);
         else repeat ($urandom_range(10, 40)) @(posedge clock);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send(input logic [CMD_W-1:0] c, input logic [FRAME_W-1:0] f,
                       input logic typed, input lru_rsp_type k, input bit quiet);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= c;
      req_chan.frame <= f;
      known_on       <= typed;
      known_rsp      <= k;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      req_total++;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (lru_rsp_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [COUNT_W-1:0] v);
      drain();
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic plan_row_type req_row(logic [CMD_W-1:0] c, logic [FRAME_W-1:0] f,
                                            logic typed, logic fd,
                                            logic [FRAME_W-1:0] of,
                                            logic [COUNT_W-1:0] occ);
      plan_row_type p;
      p               = '0;
      p.kind          = ROW_REQ;
      p.cmd           = c;
      p.frame         = f;
      p.typed         = typed;
      p.rsp.found     = fd;
      p.rsp.out_frame = of;
      p.rsp.occupancy = occ;
      return p;
   endfunction

   function automatic plan_row_type cap_row(logic [COUNT_W-1:0] v);
      plan_row_type p;
      p      = '0;
      p.kind = ROW_CAP;
      p.cap  = v;
      return p;
   endfunction

   initial begin : stimulus
      logic [CMD_W-1:0]   c;
      logic [FRAME_W-1:0] f;
      logic [FRAME_W-1:0] mask;
      logic [FRAME_W-1:0] flip;
      logic [COUNT_W-1:0] cap;
      int n;
      int r;
      int unpin_pct;
      int pin_pct;
      bit quiet;

      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.cmd   <= CMD_VICTIM;
      req_chan.frame <= '0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      known_on       <= 1'b0;
      known_rsp      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      directed_plan.push_back(req_row(CMD_VICTIM,   0,  1, 0, 0,  0));
      directed_plan.push_back(req_row(CMD_RESERVED, 63, 1, 0, 0,  0));
      directed_plan.push_back(req_row(CMD_PIN,      5,  1, 0, 0,  0));
      directed_plan.push_back(req_row(CMD_UNPIN,    63, 1, 0, 0,  1));
      directed_plan.push_back(req_row(CMD_UNPIN,    0,  1, 0, 0,  2));
      directed_plan.push_back(req_row(CMD_UNPIN,    63, 1, 0, 0,  2));
      directed_plan.push_back(req_row(CMD_VICTIM,   0,  1, 1, 0,  1));
      directed_plan.push_back(req_row(CMD_PIN,      63, 1, 0, 0,  0));
      directed_plan.push_back(cap_row(1));
      directed_plan.push_back(req_row(CMD_UNPIN,    10, 1, 0, 0,  1));
      directed_plan.push_back(req_row(CMD_UNPIN,    20, 1, 1, 10, 1));
      directed_plan.push_back(req_row(CMD_UNPIN,    20, 1, 1, 20, 1));
      directed_plan.push_back(cap_row(0));
      directed_plan.push_back(req_row(CMD_UNPIN,    42, 1, 1, 20, 1));
      directed_plan.push_back(cap_row(127));
      directed_plan.push_back(req_row(CMD_UNPIN,    1,  0, 0, 0,  0));
      directed_plan.push_back(req_row(CMD_UNPIN,    2,  0, 0, 0,  0));
      directed_plan.push_back(req_row(CMD_UNPIN,    3,  0, 0, 0,  0));
      directed_plan.push_back(req_row(CMD_UNPIN,    42, 0, 0, 0,  0));
      directed_plan.push_back(req_row(CMD_PIN,      2,  0, 0, 0,  0));
      directed_plan.push_back(cap_row(2));
      directed_plan.push_back(req_row(CMD_UNPIN,    7,  0, 0, 0,  0));
      directed_plan.push_back(req_row(CMD_RESERVED, 0,  0, 0, 0,  0));
      directed_plan.push_back(req_row(CMD_VICTIM,   0,  0, 0, 0,  0));
      directed_plan.push_back(req_row(CMD_VICTIM,   0,  0, 0, 0,  0));
      directed_plan.push_back(req_row(CMD_VICTIM,   0,  1, 0, 0,  0));
      directed_plan.push_back(cap_row(64));

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CAP) begin
            write_capacity(directed_plan[i].cap);
         end else begin
            send(directed_plan[i].cmd, directed_plan[i].frame, directed_plan[i].typed,
                 directed_plan[i].rsp, 1'b0);
         end
      end

      while (req_total < REQUEST_TOTAL) begin
         case ($urandom_range(0, 9))
            0:       cap = 0;
            1:       cap = 1;
            2:       cap = 64;
            3:       cap = 127;
            4, 5:    cap = COUNT_W'($urandom_range(2, 8));
            6:       cap = COUNT_W'($urandom_range(65, 126));
            default: cap = COUNT_W'($urandom_range(1, 64));
         endcase
         write_capacity(cap);
         case ($urandom_range(0, 3))
            0:       mask = 6'h3f;
            1:       mask = 6'h0f;
            2:       mask = 6'h07;
            default: mask = 6'h03;
         endcase
         flip      = FRAME_W'($urandom);
         quiet     = ($urandom_range(0, 5) == 0);
         unpin_pct = $urandom_range(40, 85);
         pin_pct   = (97 - unpin_pct) / 2;
         n         = $urandom_range(30, 150);
         repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 3) c = CMD_RESERVED;
            else if (r < 3 + unpin_pct) c = CMD_UNPIN;
            else if (r < 3 + unpin_pct + pin_pct) c = CMD_PIN;
            else c = CMD_VICTIM;
            f = (FRAME_W'($urandom) & mask) ^ flip;
            send(c, f, 1'b0, '0, quiet);
            if ($urandom_range(0, 99) == 0) drain();
         end
      end

      drain();
      repeat (150) @(posedge clock);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
